>>> rtl/core/q2e_pkg.sv
// shared types, constants and functions of the quaternion to euler unit
`default_nettype none
package q2e_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SQRT_STEPS = 29;
  localparam int XY_W = 38;
  localparam int ANG_W = 34;
  localparam int ROOT_W = 60;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1 <<< 30);

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
    logic                    hold;
  } lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
  } root_t;

  // arctan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // quadrant fold and the zero-x cases ahead of the vectoring cells
  function automatic lane_t cordic_pre(input logic signed [XY_W-1:0] y,
                                       input logic signed [XY_W-1:0] x);
    lane_t l;
    l.x = x;
    l.y = y;
    l.ang = '0;
    l.hold = 1'b0;
    if (x == '0) begin
      l.hold = 1'b1;
      if (y > 0) begin
        l.ang = QUARTER_TURN;
      end else if (y < 0) begin
        l.ang = -QUARTER_TURN;
      end
    end else if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.ang = QUARTER_TURN;
      end else begin
        l.x = -y;
        l.y = x;
        l.ang = -QUARTER_TURN;
      end
    end
    return l;
  endfunction

  // round half up to a 16-bit binary angle
  function automatic logic [15:0] to_bam(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] s;
    s = a + ANG_W'(32768);
    return s[31:16];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/q2e_root_cell.sv
// one restoring square root step, registered
`default_nettype none
module q2e_root_cell #(
  parameter int K = 0
) (
  input  wire logic           clk,
  input  wire q2e_pkg::root_t din,
  output q2e_pkg::root_t      dout
);
  import q2e_pkg::*;

  localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * K);

  logic [ROOT_W-1:0] trial;

  assign trial = din.res + BIT;

  always_ff @(posedge clk) begin
    if (din.rem >= trial) begin
      dout.rem <= din.rem - trial;
      dout.res <= (din.res >> 1) + BIT;
    end else begin
      dout.rem <= din.rem;
      dout.res <= din.res >> 1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/q2e_cordic_cell.sv
// one cordic vectoring step, registered
`default_nettype none
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  wire logic           clk,
  input  wire q2e_pkg::lane_t din,
  output q2e_pkg::lane_t      dout
);
  import q2e_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(atan_val(5'(I)));

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = din.y >>> I;
  assign dy = din.x >>> I;

  always_ff @(posedge clk) begin
    dout.hold <= din.hold;
    if (din.hold) begin
      dout.x <= din.x;
      dout.y <= din.y;
      dout.ang <= din.ang;
    end else if (din.y > 0) begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.ang <= din.ang + STEP_ANG;
    end else begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.ang <= din.ang - STEP_ANG;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/quaternion_to_euler_unit.sv
// quaternion to euler angle converter: top level
// Takes one quaternion word in every cycle (busy stays low) and returns its three angles,
// marked by a one-cycle done strobe; the receiver cannot stall. The pipeline consists of
// four front stages, the chain of 29 square root cells that forms the cosine for the
// asin path, one quadrant fold stage ahead of the vectoring cells, the chain of
// CORDIC_STEPS vectoring cells shared in form by the three angles, and one output stage.
`default_nettype none
module quaternion_to_euler_unit #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    done,
  output logic signed [15:0]      angle_z,
  output logic signed [15:0]      angle_x,
  output logic signed [15:0]      angle_y,
  output logic                    asin_clamped
);
  import q2e_pkg::*;

  localparam int LAT = 35 + CORDIC_STEPS;
  localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [ROOT_W-1:0] ONE_SQ = ROOT_W'(64'sd1 <<< 56);

  logic [LAT-1:0] vld;

  logic signed [15:0] w, x, y, z;
  logic signed [31:0] p_wz, p_xy, p_zz, p_xx, p_wx, p_yz, p_wy, p_zx, p_yy;
  logic signed [35:0] zy_a, zx_a, zy_b, zx_b;
  logic signed [35:0] s_full;
  logic signed [29:0] s_c;
  logic               clamp_c;
  logic signed [35:0] zy_a3, zx_a3, zy_b3, zx_b3;
  logic signed [29:0] s3;
  logic               clamp3;
  logic signed [59:0] ss;

  // side payload carried alongside the root cells
  logic signed [35:0] d_zy_a [SQRT_STEPS];
  logic signed [35:0] d_zx_a [SQRT_STEPS];
  logic signed [35:0] d_zy_b [SQRT_STEPS];
  logic signed [35:0] d_zx_b [SQRT_STEPS];
  logic signed [29:0] d_s [SQRT_STEPS];
  logic               d_cl [SQRT_STEPS];

  root_t root [SQRT_STEPS+1];
  lane_t lz [CORDIC_STEPS+1];
  lane_t lx [CORDIC_STEPS+1];
  lane_t ly [CORDIC_STEPS+1];
  logic  cl [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] ax_lim;
  logic [ROOT_W-1:0] c_root;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    w <= quat_w;
    x <= quat_x;
    y <= quat_y;
    z <= quat_z;
    p_wz <= 32'(w) * 32'(z);
    p_xy <= 32'(x) * 32'(y);
    p_zz <= 32'(z) * 32'(z);
    p_xx <= 32'(x) * 32'(x);
    p_wx <= 32'(w) * 32'(x);
    p_yz <= 32'(y) * 32'(z);
    p_wy <= 32'(w) * 32'(y);
    p_zx <= 32'(z) * 32'(x);
    p_yy <= 32'(y) * 32'(y);
  end

  always_comb begin
    zy_a = (36'(p_wz) + 36'(p_xy)) <<< 1;
    zx_a = ONE_Q28 - ((36'(p_zz) + 36'(p_xx)) <<< 1);
    zy_b = (36'(p_wy) + 36'(p_zx)) <<< 1;
    zx_b = ONE_Q28 - ((36'(p_xx) + 36'(p_yy)) <<< 1);
    s_full = (36'(p_wx) - 36'(p_yz)) <<< 1;
    if (s_full > ONE_Q28) begin
      s_c = 30'(ONE_Q28);
      clamp_c = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      s_c = 30'(-ONE_Q28);
      clamp_c = 1'b1;
    end else begin
      s_c = 30'(s_full);
      clamp_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    zy_a3 <= zy_a;
    zx_a3 <= zx_a;
    zy_b3 <= zy_b;
    zx_b3 <= zx_b;
    s3 <= s_c;
    clamp3 <= clamp_c;
  end

  assign ss = 60'(s3) * 60'(s3);

  always_ff @(posedge clk) begin
    root[0].rem <= ROOT_W'(ONE_SQ - ss);
    root[0].res <= '0;
    d_zy_a[0] <= zy_a3;
    d_zx_a[0] <= zx_a3;
    d_zy_b[0] <= zy_b3;
    d_zx_b[0] <= zx_b3;
    d_s[0] <= s3;
    d_cl[0] <= clamp3;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    q2e_root_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
      .clk  (clk),
      .din  (root[j]),
      .dout (root[j+1])
    );
    if (j > 0) begin : g_dly
      always_ff @(posedge clk) begin
        d_zy_a[j] <= d_zy_a[j-1];
        d_zx_a[j] <= d_zx_a[j-1];
        d_zy_b[j] <= d_zy_b[j-1];
        d_zx_b[j] <= d_zx_b[j-1];
        d_s[j] <= d_s[j-1];
        d_cl[j] <= d_cl[j-1];
      end
    end
  end

  // root register holds one stage more than the side line, so take the side at its end
  logic signed [35:0] e_zy_a, e_zx_a, e_zy_b, e_zx_b;
  logic signed [29:0] e_s;
  logic               e_cl;

  always_ff @(posedge clk) begin
    e_zy_a <= d_zy_a[SQRT_STEPS-1];
    e_zx_a <= d_zx_a[SQRT_STEPS-1];
    e_zy_b <= d_zy_b[SQRT_STEPS-1];
    e_zx_b <= d_zx_b[SQRT_STEPS-1];
    e_s <= d_s[SQRT_STEPS-1];
    e_cl <= d_cl[SQRT_STEPS-1];
  end

  assign c_root = root[SQRT_STEPS].res;

  always_ff @(posedge clk) begin
    lz[0] <= cordic_pre(XY_W'(e_zy_a), XY_W'(e_zx_a));
    ly[0] <= cordic_pre(XY_W'(e_zy_b), XY_W'(e_zx_b));
    lx[0] <= cordic_pre(XY_W'(e_s), XY_W'(c_root));
    cl[0] <= e_cl;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    q2e_cordic_cell #(.I(i)) u_z (.clk(clk), .din(lz[i]), .dout(lz[i+1]));
    q2e_cordic_cell #(.I(i)) u_x (.clk(clk), .din(lx[i]), .dout(lx[i+1]));
    q2e_cordic_cell #(.I(i)) u_y (.clk(clk), .din(ly[i]), .dout(ly[i+1]));
    always_ff @(posedge clk) begin
      cl[i+1] <= cl[i];
    end
  end

  always_comb begin
    ax_lim = lx[CORDIC_STEPS].ang;
    if (ax_lim > QUARTER_TURN) begin
      ax_lim = QUARTER_TURN;
    end else if (ax_lim < -QUARTER_TURN) begin
      ax_lim = -QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    angle_z <= to_bam(lz[CORDIC_STEPS].ang);
    angle_x <= to_bam(ax_lim);
    angle_y <= to_bam(ly[CORDIC_STEPS].ang);
    asin_clamped <= cl[CORDIC_STEPS];
  end

  assign done = vld[LAT-1];

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("done without a matching start");

  a_clamp_gives_right_angle: assert property (@(posedge clk) disable iff (rst)
    (done && asin_clamped) |-> (angle_x == 16'sd16384 || angle_x == -16'sd16384))
    else $error("clamped asin not at a quarter turn");

  a_angle_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_x <= 16'sd16384 && angle_x >= -16'sd16384))
    else $error("angle_x out of range");

endmodule
`default_nettype wire

>>> sim/quaternion_to_euler_unit_tb.sv
// testbench for the quaternion to euler unit: predicts the three angles and the clamp flag and compares
`default_nettype none
module quaternion_to_euler_unit_tb;

  localparam int STEPS = q2e_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = 35 + STEPS;
  localparam longint ONE = 64'sd1 << 28;
  localparam longint QTR = 64'sd1 << 30;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit drain;
  } quat_t;

  typedef struct {
    logic signed [15:0] az, ax, ay;
    logic clamped;
  } angles_t;

  localparam longint ATAN_TAB [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic done;
  logic signed [15:0] angle_z, angle_x, angle_y;
  logic asin_clamped;

  quat_t pending_q[$];
  angles_t angle_exp_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int cyc = 0;

  quaternion_to_euler_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .angle_z(angle_z), .angle_x(angle_x), .angle_y(angle_y),
    .asin_clamped(asin_clamped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring atan2, 2^32 units per turn
  function automatic longint vector_angle(input longint y, input longint x);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0) return (y > 0) ? QTR : (y < 0) ? -QTR : 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = QTR;
      end else begin
        x = -y; y = t; ang = -QTR;
      end
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; ang -= ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic logic [15:0] bam16(input longint a);
    longint r;
    r = (a + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(input quat_t q);
    angles_t r;
    longint w, x, y, z, s, ax;
    longint unsigned c;
    w = longint'(q.w); x = longint'(q.x); y = longint'(q.y); z = longint'(q.z);
    r.clamped = 1'b0;
    s = 2 * (w * x - y * z);
    if (s > ONE) begin
      s = ONE; r.clamped = 1'b1;
    end else if (s < -ONE) begin
      s = -ONE; r.clamped = 1'b1;
    end
    c = int_sqrt(longint'(ONE * ONE) - s * s);
    ax = vector_angle(s, longint'(c));
    if (ax > QTR) ax = QTR;
    if (ax < -QTR) ax = -QTR;
    r.az = bam16(vector_angle(2 * (w * z + x * y), ONE - 2 * (z * z + x * x)));
    r.ax = bam16(ax);
    r.ay = bam16(vector_angle(2 * (w * y + z * x), ONE - 2 * (x * x + y * y)));
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cyc, got, want);
    errors++;
  endtask

  task automatic add(input int w, input int x, input int y, input int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.drain = 1'b0;
    pending_q.push_back(q);
  endtask

  task automatic add_unit();
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(0, 2000))) - 1000.0;
    b = $itor($signed($urandom_range(0, 2000))) - 1000.0;
    c = $itor($signed($urandom_range(0, 2000))) - 1000.0;
    d = $itor($signed($urandom_range(0, 2000))) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      add(16384, 0, 0, 0);
    end else begin
      add($rtoi(16384.0 * a / n), $rtoi(16384.0 * b / n), $rtoi(16384.0 * c / n),
          $rtoi(16384.0 * d / n));
    end
  endtask

  // stimulus
  initial begin
    quat_t mark;
    add(16384, 0, 0, 0);
    add(0, 0, 0, 0);
    add(-16384, 0, 0, 0);
    add(0, 16384, 0, 0);
    add(0, 0, 16384, 0);
    add(0, 0, 0, 16384);
    add(0, 0, 0, -16384);
    add(16384, 16384, 0, 0);      // asin clamped high
    add(16384, -16384, 0, 0);     // asin clamped low
    add(11585, 11585, 0, 0);      // gimbal lock
    add(11585, -11585, 0, 0);
    add(0, 8192, 0, 8192);        // both atan2 operands zero
    add(16384, 8192, 0, 8192);    // zero x operand
    add(-16384, 8192, 0, 8192);
    add(0, 0, 16384, 16384);      // negative x operand
    add(16384, 0, -16384, 16384);
    add(32767, 32767, 32767, 32767);
    add(-32768, -32768, -32768, -32768);
    add(-32768, 32767, -32768, 32767);
    add(-16384, -16384, -16384, -16384);
    add(16384, 16384, 16384, 16384);
    add(-1, -1, -1, -1);
    for (int i = 0; i < 750; i++) begin
      if (i == 300) begin
        mark = '{default: '0};
        mark.drain = 1'b1;
        pending_q.push_back(mark);
      end
      case ($urandom_range(0, 9))
        0: add($urandom, $urandom, $urandom, $urandom);
        1, 2: add($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                  $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        default: add_unit();
      endcase
    end
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // driver
  always @(negedge clk) begin
    quat_t q;
    if (!rst) begin
      if (start && !took) begin
        // held until taken
      end else if (took && start && pending_q.size() != 0 && burst_left > 0
                   && !pending_q[0].drain) begin
        q = pending_q.pop_front();
        quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
        burst_left <= burst_left - 1;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
        if (gap_left == 1) burst_left <= $urandom_range(1, 30);
      end else if (pending_q.size() != 0 && pending_q[0].drain) begin
        start <= 1'b0;
        if (angle_exp_q.size() == 0) void'(pending_q.pop_front());
      end else if (pending_q.size() != 0) begin
        if (burst_left == 0 && took) begin
          start <= 1'b0;
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap_left == 0) burst_left <= $urandom_range(1, 30);
        end else begin
          q = pending_q.pop_front();
          quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
          start <= 1'b1;
          burst_left <= (burst_left == 0) ? $urandom_range(1, 30) : burst_left - 1;
        end
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // acceptance and result check
  always @(posedge clk) begin
    quat_t q;
    angles_t e;
    cyc <= cyc + 1;
    took <= 1'b0;
    if (!rst && start && !busy) begin
      q.w = quat_w; q.x = quat_x; q.y = quat_y; q.z = quat_z; q.drain = 1'b0;
      angle_exp_q.push_back(predict_angles(q));
      took <= 1'b1;
    end
    if (!rst && done) begin
      if (angle_exp_q.size() == 0) begin
        $display("unexpected result word at cycle %0d", cyc);
        errors++;
      end else begin
        e = angle_exp_q.pop_front();
        if (angle_z !== e.az) report("angle_z", int'(angle_z), int'(e.az));
        if (angle_x !== e.ax) report("angle_x", int'(angle_x), int'(e.ax));
        if (angle_y !== e.ay) report("angle_y", int'(angle_y), int'(e.ay));
        if (asin_clamped !== e.clamped) begin
          report("asin_clamped", int'(asin_clamped), int'(e.clamped));
        end
      end
    end
  end

  initial begin
    wait (stim_done && angle_exp_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && angle_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
